FILE: rtl/core/rtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared constants for the region thread-count search block: search phase
// codes, register indexes, register reset values and parameter defaults.
// ----------------------------------------------------------------------------
package rtc_pkg;

   localparam int DEF_REGION_SLOTS = 32;
   localparam int DEF_THREAD_BITS  = 9;

   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_REPEAT = 3'd0;
   localparam logic [PHASE_W-1:0] PH_DOUBLE = 3'd1;
   localparam logic [PHASE_W-1:0] PH_STEP   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_TRIAL  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DONE   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_FINE   = 3'd5;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_THREADS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_METRIC  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_THRESHOLD = 2'd3;

   localparam logic [8:0]  RST_CORE_COUNT      = 9'd8;
   localparam logic [8:0]  RST_START_THREADS   = 9'd2;
   localparam logic        RST_INITIAL_METRIC  = 1'b0;
   localparam logic [31:0] RST_BOOST_THRESHOLD = 32'd740;

endpackage

FILE: rtl/core/region_thread_count_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_thread_count_search
// Region key lookup and per-region thread/boost search kept in a record RAM.
// ----------------------------------------------------------------------------
// Result path: after the request transfer, key match and RAM read, then update
//   and write-back into the result register; the update waits while it is held.
// Requests: taken only in the idle state, so one request in flight at a time;
//   the next one waits until the previous result enters the result register.
// Reset: synchronous; clears fill count, previous slot, handshake state; sets
//   prev boost, CSR defaults; no clearing pass, RAM set on slot allocation.
module region_thread_count_search #(
   parameter int REGION_SLOTS = rtc_pkg::DEF_REGION_SLOTS,
   parameter int THREAD_BITS  = rtc_pkg::DEF_THREAD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [63:0]                  req_region_key,
   input  logic [31:0]                  req_elapsed_time,
   input  logic signed [31:0]           req_energy,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [8:0]                   rsp_thread_count,
   output logic                         rsp_boost_write,
   output logic                         rsp_boost_value,
   output logic                         rsp_table_full,
   input  logic                         csr_write,
   input  logic [rtc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                  csr_data
);
   import rtc_pkg::*;

   localparam int IW    = $clog2(REGION_SLOTS);
   localparam int REC_W = 133 + 4 * THREAD_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [63:0]        key_ff;
   logic [31:0]        time_ff;
   logic signed [31:0] energy_ff;
   logic signed [63:0] prod_ff;
   logic [IW-1:0]      slot_ff, prev_slot_ff;
   logic               fresh_ff, prev_boost_ff;
   logic [8:0]         core_count_ff, start_threads_ff;
   logic               initial_metric_ff;
   logic [31:0]        boost_threshold_ff;
   logic               rsp_valid_ff;
   logic [8:0]         rsp_thread_count_ff;
   logic               rsp_boost_write_ff, rsp_boost_value_ff, rsp_table_full_ff;

   logic               lk_hit, lk_full;
   logic [IW-1:0]      lk_slot;
   logic [REC_W-1:0]   rd_rec, wr_rec;
   logic [8:0]         up_threads;
   logic               up_write, up_value, up_boost;
   logic               out_free, commit, accept;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == ST_CALC) && out_free;

   rtc_tags #(.REGION_SLOTS(REGION_SLOTS)) u_tags (
      .clock     (clock),
      .reset     (reset),
      .key       (key_ff),
      .hit       (lk_hit),
      .full      (lk_full),
      .slot      (lk_slot),
      .alloc     (commit && fresh_ff),
      .alloc_key (key_ff)
   );

   rtc_mem #(.DEPTH(REGION_SLOTS), .WIDTH(REC_W)) u_mem (
      .clock   (clock),
      .rd_en   (state_ff == ST_LOOK),
      .rd_addr (lk_slot),
      .rd_data (rd_rec),
      .wr_en   (commit),
      .wr_addr (slot_ff),
      .wr_data (wr_rec)
   );

   rtc_update #(.THREAD_BITS(THREAD_BITS), .REC_W(REC_W)) u_update (
      .fresh           (fresh_ff),
      .rec_in          (rd_rec),
      .elapsed_time    (time_ff),
      .product         (prod_ff),
      .initial_metric  (initial_metric_ff),
      .start_threads   (start_threads_ff),
      .core_count      (core_count_ff),
      .boost_threshold (boost_threshold_ff),
      .same_prev       (prev_slot_ff == slot_ff),
      .prev_boost      (prev_boost_ff),
      .rec_out         (wr_rec),
      .thread_count    (up_threads),
      .boost_write     (up_write),
      .boost_value     (up_value),
      .new_boost       (up_boost)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = ST_LOOK;
         end
         ST_LOOK: state_in = lk_full ? ST_FULL : ST_CALC;
         ST_CALC: if (out_free) begin
            state_in = ST_IDLE;
         end
         ST_FULL: if (out_free) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         rsp_valid_ff       <= 1'b0;
         prev_slot_ff       <= '0;
         prev_boost_ff      <= 1'b1;
         core_count_ff      <= RST_CORE_COUNT;
         start_threads_ff   <= RST_START_THREADS;
         initial_metric_ff  <= RST_INITIAL_METRIC;
         boost_threshold_ff <= RST_BOOST_THRESHOLD;
      end else begin
         state_ff <= state_in;
         if (commit || ((state_ff == ST_FULL) && out_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit) begin
            prev_slot_ff  <= slot_ff;
            prev_boost_ff <= up_boost;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_CORE_COUNT:      core_count_ff      <= csr_data[8:0];
               CSR_START_THREADS:   start_threads_ff   <= csr_data[8:0];
               CSR_INITIAL_METRIC:  initial_metric_ff  <= csr_data[0];
               CSR_BOOST_THRESHOLD: boost_threshold_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff    <= req_region_key;
         time_ff   <= req_elapsed_time;
         energy_ff <= req_energy;
      end
      if (state_ff == ST_LOOK) begin
         prod_ff  <= $signed({1'b0, time_ff}) * energy_ff;
         slot_ff  <= lk_slot;
         fresh_ff <= !lk_hit;
      end
      if (commit) begin
         rsp_thread_count_ff <= up_threads;
         rsp_boost_write_ff  <= up_write;
         rsp_boost_value_ff  <= up_value;
         rsp_table_full_ff   <= 1'b0;
      end else if ((state_ff == ST_FULL) && out_free) begin
         rsp_thread_count_ff <= '0;
         rsp_boost_write_ff  <= 1'b0;
         rsp_boost_value_ff  <= 1'b0;
         rsp_table_full_ff   <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_thread_count = rsp_thread_count_ff;
   assign rsp_boost_write  = rsp_boost_write_ff;
   assign rsp_boost_value  = rsp_boost_value_ff;
   assign rsp_table_full   = rsp_table_full_ff;
endmodule

FILE: rtl/core/rtc_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_mem
// Region record memory with one read and one write port, registered read.
// ----------------------------------------------------------------------------
module rtc_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/rtc_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_tags
// Region key store: parallel key match over allocated slots, fill count and
// allocation of the next free slot.
// ----------------------------------------------------------------------------
module rtc_tags #(
   parameter int REGION_SLOTS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [63:0]                     key,
   output logic                            hit,
   output logic                            full,
   output logic [$clog2(REGION_SLOTS)-1:0] slot,
   input  logic                            alloc,
   input  logic [63:0]                     alloc_key
);
   localparam int IW = $clog2(REGION_SLOTS);
   localparam int CW = $clog2(REGION_SLOTS + 1);

   logic [63:0]       tags_ff [REGION_SLOTS];
   logic [CW-1:0]     count_ff, count_in;
   logic [REGION_SLOTS-1:0] match;
   logic [IW-1:0]     match_idx;

   // keys are unique among allocated slots, so OR of indexes gives the matching slot
   always_comb begin
      match_idx = '0;
      for (int i = 0; i < REGION_SLOTS; i++) begin
         match[i] = (CW'(i) < count_ff) && (tags_ff[i] == key);
         if (match[i]) begin
            match_idx = match_idx | IW'(i);
         end
      end
   end

   assign hit  = |match;
   assign full = !hit && (count_ff == CW'(REGION_SLOTS));
   assign slot = hit ? match_idx : count_ff[IW-1:0];

   always_comb begin
      count_in = count_ff;
      if (alloc) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc) begin
         tags_ff[count_ff[IW-1:0]] <= alloc_key;
      end
   end
endmodule

FILE: rtl/core/rtc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_update
// Next-state logic of one region record: score, search phase step and boost
// decision.
// ----------------------------------------------------------------------------
module rtc_update #(
   parameter int THREAD_BITS = 9,
   parameter int REC_W = 133 + 4 * THREAD_BITS
) (
   input  logic               fresh,
   input  logic [REC_W-1:0]   rec_in,
   input  logic [31:0]        elapsed_time,
   input  logic signed [63:0] product,
   input  logic               initial_metric,
   input  logic [8:0]         start_threads,
   input  logic [8:0]         core_count,
   input  logic [31:0]        boost_threshold,
   input  logic               same_prev,
   input  logic               prev_boost,
   output logic [REC_W-1:0]   rec_out,
   output logic [8:0]         thread_count,
   output logic               boost_write,
   output logic               boost_value,
   output logic               new_boost
);
   import rtc_pkg::*;
   localparam int TB = THREAD_BITS;

   logic [PHASE_W-1:0] m_phase, phase;
   logic               m_metric, metric;
   logic [TB-1:0]      m_tn, m_lt, m_st, m_bt;
   logic [TB-1:0]      tn, lt, st, bt, nxt;
   logic signed [63:0] m_br, br, res, thr;
   logic [31:0]        m_twb, m_twob, twb, twob;
   logic               m_bb, bb, pbb, wr, val;
   logic [32:0]        sum_on, sum_off;

   assign {m_phase, m_metric, m_tn, m_lt, m_st, m_bt, m_br, m_twb, m_twob, m_bb} = rec_in;

   always_comb begin
      if (fresh) begin
         phase = PH_REPEAT; metric = initial_metric;
         tn = '0; lt = '0; st = '0; bt = '0; br = '0;
         twb = '0; twob = '0; bb = 1'b1;
      end else begin
         phase = m_phase; metric = m_metric;
         tn = m_tn; lt = m_lt; st = m_st; bt = m_bt; br = m_br;
         twb = m_twb; twob = m_twob; bb = m_bb;
      end
      nxt = '0;
      wr  = 1'b0;
      val = 1'b0;
      thr = $signed({32'd0, boost_threshold});
      res = metric ? product : $signed({32'd0, elapsed_time});
      sum_on  = {1'b0, twb} + {1'b0, boost_threshold};
      sum_off = {1'b0, twob} + {1'b0, boost_threshold};
      if (phase != PH_DONE) begin
         if (metric && res <= 0) begin
            phase  = PH_REPEAT;
            metric = 1'b0;
         end
         case (phase)
            PH_REPEAT: begin
               phase = PH_DOUBLE;
               tn = TB'(start_threads);
               nxt = tn;
               lt = tn;
            end
            PH_DOUBLE: begin
               br = res;
               bt = tn;
               tn = tn << 1;
               nxt = tn;
               phase = PH_STEP;
            end
            PH_STEP: begin
               if (res < br) begin
                  br = res;
                  bt = tn;
                  if ((32'(tn) << 1) <= 32'(core_count)) begin
                     lt = tn;
                     tn = tn << 1;
                     nxt = tn;
                  end else begin
                     st = lt >> 1;
                     if (st >= TB'(2)) begin
                        tn = tn - st;
                        nxt = tn;
                        phase = PH_FINE;
                     end else begin
                        bb = 1'b0; twb = elapsed_time; phase = PH_TRIAL;
                     end
                  end
               end else if (32'(bt) == 32'(core_count >> 1)) begin
                  bb = 1'b0; twb = elapsed_time; phase = PH_TRIAL;
               end else begin
                  st = lt >> 1;
                  if (st >= TB'(2)) begin
                     tn = tn + st;
                     nxt = tn;
                     phase = PH_FINE;
                  end else begin
                     bb = 1'b0; twb = elapsed_time; phase = PH_TRIAL;
                  end
               end
            end
            PH_FINE: begin
               if (!(br < res)) begin
                  bt = tn;
                  br = res;
               end
               st = st >> 1;
               if (st >= TB'(2)) begin
                  tn = tn + st;
                  nxt = tn;
               end else begin
                  bb = 1'b0; twb = elapsed_time; phase = PH_TRIAL;
               end
            end
            PH_TRIAL: begin
               phase = PH_DONE;
               twob = elapsed_time;
               if (br < res) begin
                  bb = 1'b1;
               end
               nxt = bt;
            end
            default: begin
            end
         endcase
         pbb = same_prev ? bb : prev_boost;
         if (phase != PH_TRIAL && bb != pbb && br > thr) begin
            wr  = 1'b1;
            val = bb;
         end
      end else begin
         pbb = same_prev ? bb : prev_boost;
         if ((!pbb && bb && sum_on < {1'b0, twob}) ||
             (pbb && !bb && sum_off < {1'b0, twb})) begin
            wr  = 1'b1;
            val = bb;
         end
         nxt = bt;
      end
   end

   assign rec_out      = {phase, metric, tn, lt, st, bt, br, twb, twob, bb};
   assign thread_count = 9'(nxt);
   assign boost_write  = wr;
   assign boost_value  = val;
   assign new_boost    = bb;
endmodule

FILE: rtl/core/rtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_checker
// Port-level checks of the region thread-count search block.
// ----------------------------------------------------------------------------
module rtc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [8:0] rsp_thread_count,
   input logic       rsp_boost_write,
   input logic       rsp_boost_value,
   input logic       rsp_table_full
);
   // a refused item carries nothing else
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_thread_count == 9'd0 && !rsp_boost_write)
      else $error("table_full result carries data");

   a_value_needs_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_boost_write |-> !rsp_boost_value)
      else $error("boost_value set without boost_write");

   // one request in flight: a transfer is followed by a stall
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("back-to-back request transfers");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");
endmodule

bind region_thread_count_search rtc_checker u_rtc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_thread_count (rsp_thread_count),
   .rsp_boost_write  (rsp_boost_write),
   .rsp_boost_value  (rsp_boost_value),
   .rsp_table_full   (rsp_table_full)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for region_thread_count_search. A local per-region
// search model predicts every result at request transfer time; a monitor
// compares each response transfer against the oldest prediction. Tests cover
// directed phase walks and field extremes, several register settings with
// random traffic, a long response hold-off and table overflow.
// ----------------------------------------------------------------------------
module tb_top;
   import rtc_pkg::*;

   localparam int SLOTS      = DEF_REGION_SLOTS;
   localparam int TMASK      = (1 << DEF_THREAD_BITS) - 1;
   localparam int IDLE_LIMIT = 4000;
   localparam int POOL_N     = 28;

   typedef struct packed {
      logic [8:0] threads;
      logic       boost_wr;
      logic       boost_val;
      logic       full;
   } region_rsp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [63:0]        req_region_key;
   logic [31:0]        req_elapsed_time;
   logic signed [31:0] req_energy;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [8:0]         rsp_thread_count;
   logic               rsp_boost_write;
   logic               rsp_boost_value;
   logic               rsp_table_full;
   logic               csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]        csr_data;

   region_thread_count_search uut (.*);

   // shadow registers and per-region search state
   int          cfg_cores;
   int          cfg_start;
   bit          cfg_edp;
   logic [31:0] cfg_thresh;
   logic [63:0] tags[SLOTS];
   int          used_regions;
   logic [2:0]  phase[SLOTS];
   bit          edp_metric[SLOTS];
   int          thr_now[SLOTS];
   int          thr_last[SLOTS];
   int          thr_step[SLOTS];
   int          thr_best[SLOTS];
   longint      score_best[SLOTS];
   longint      t_boost_on[SLOTS];
   longint      t_boost_off[SLOTS];
   bit          boost_best[SLOTS];
   int          prev_region;

   region_rsp_type expected_rsp[$];
   logic [63:0] key_pool[POOL_N];
   int          fail_count;
   bit          burst_mode;
   bit          long_hold;
   int          idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void start_boost_trial(input int r, input logic [31:0] tm);
      boost_best[r] = 1'b0;
      t_boost_on[r] = longint'({32'b0, tm});
      phase[r] = PH_TRIAL;
   endfunction

   function automatic region_rsp_type search_step_predict(input logic [63:0] key,
         input logic [31:0] tm, input logic signed [31:0] en);
      int          r;
      int          p;
      int          next_thr;
      bit          wr;
      bit          val;
      longint      score;
      longint      tm64;
      longint      th64;
      region_rsp_type o;
      o = '0;
      r = -1;
      tm64 = longint'({32'b0, tm});
      th64 = longint'({32'b0, cfg_thresh});
      for (int i = 0; i < used_regions; i++)
         if (r < 0 && tags[i] == key) r = i;
      if (r < 0) begin
         if (used_regions >= SLOTS) begin
            o.full = 1'b1;
            return o;
         end
         r = used_regions;
         tags[r] = key;
         edp_metric[r] = cfg_edp;
         used_regions++;
      end
      p = prev_region;
      wr = 1'b0;
      val = 1'b0;
      next_thr = 0;
      if (phase[r] != PH_DONE) begin
         if (!edp_metric[r]) begin
            score = tm64;
         end else begin
            score = tm64 * longint'(en);
            // nonpositive EDP falls back to a fresh time-based search
            if (score <= 0) begin
               phase[r] = PH_REPEAT;
               edp_metric[r] = 1'b0;
            end
         end
         case (phase[r])
            PH_REPEAT: begin
               phase[r] = PH_DOUBLE;
               thr_now[r] = cfg_start & TMASK;
               next_thr = thr_now[r];
               thr_last[r] = thr_now[r];
            end
            PH_DOUBLE: begin
               score_best[r] = score;
               thr_best[r] = thr_now[r];
               thr_now[r] = (thr_now[r] * 2) & TMASK;
               next_thr = thr_now[r];
               phase[r] = PH_STEP;
            end
            PH_STEP: begin
               if (score < score_best[r]) begin
                  score_best[r] = score;
                  thr_best[r] = thr_now[r];
                  if (thr_now[r] * 2 <= cfg_cores) begin
                     thr_last[r] = thr_now[r];
                     thr_now[r] = (thr_now[r] * 2) & TMASK;
                     next_thr = thr_now[r];
                  end else begin
                     thr_step[r] = thr_last[r] / 2;
                     if (thr_step[r] >= 2) begin
                        thr_now[r] = (thr_now[r] - thr_step[r]) & TMASK;
                        next_thr = thr_now[r];
                        phase[r] = PH_FINE;
                     end else begin
                        start_boost_trial(r, tm);
                     end
                  end
               end else if (thr_best[r] == cfg_cores / 2) begin
                  start_boost_trial(r, tm);
               end else begin
                  thr_step[r] = thr_last[r] / 2;
                  if (thr_step[r] >= 2) begin
                     thr_now[r] = (thr_now[r] + thr_step[r]) & TMASK;
                     next_thr = thr_now[r];
                     phase[r] = PH_FINE;
                  end else begin
                     start_boost_trial(r, tm);
                  end
               end
            end
            PH_FINE: begin
               if (!(score_best[r] < score)) begin
                  thr_best[r] = thr_now[r];
                  score_best[r] = score;
               end
               thr_step[r] = thr_step[r] / 2;
               if (thr_step[r] >= 2) begin
                  thr_now[r] = (thr_now[r] + thr_step[r]) & TMASK;
                  next_thr = thr_now[r];
               end else begin
                  start_boost_trial(r, tm);
               end
            end
            PH_TRIAL: begin
               phase[r] = PH_DONE;
               t_boost_off[r] = tm64;
               if (score_best[r] < score) boost_best[r] = 1'b1;
               next_thr = thr_best[r];
            end
            default: ;
         endcase
         if (phase[r] != PH_TRIAL && boost_best[r] != boost_best[p] &&
               score_best[r] > th64) begin
            wr = 1'b1;
            val = boost_best[r];
         end
      end else begin
         if ((!boost_best[p] && boost_best[r] &&
               t_boost_on[r] + th64 < t_boost_off[r]) ||
               (boost_best[p] && !boost_best[r] &&
               t_boost_off[r] + th64 < t_boost_on[r])) begin
            wr = 1'b1;
            val = boost_best[r];
         end
         next_thr = thr_best[r];
      end
      prev_region = r;
      o.threads = next_thr[8:0];
      o.boost_wr = wr;
      o.boost_val = val;
      return o;
   endfunction

   // one request transfer; entered and left at a falling edge
   task automatic send_item(input logic [63:0] key, input logic [31:0] tm,
         input logic signed [31:0] en, input bit no_gap);
      int gap;
      gap = (no_gap || burst_mode) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_region_key <= key;
      req_elapsed_time <= tm;
      req_energy <= en;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(search_step_predict(key, tm, en));
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_CORE_COUNT:      cfg_cores = int'(data[8:0]);
         CSR_START_THREADS:   cfg_start = int'(data[8:0]);
         CSR_INITIAL_METRIC:  cfg_edp = data[0];
         CSR_BOOST_THRESHOLD: cfg_thresh = data;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int cores, input int start, input bit edp,
         input logic [31:0] thresh);
      write_csr(CSR_CORE_COUNT, 32'(cores));
      write_csr(CSR_START_THREADS, 32'(start));
      write_csr(CSR_INITIAL_METRIC, 32'(edp));
      write_csr(CSR_BOOST_THRESHOLD, thresh);
   endtask

   task automatic test_directed();
      // time metric: decreasing times walk double, step, fine, trial, done
      for (int i = 0; i < 9; i++)
         send_item(key_pool[2], 32'd1000 - 32'(i * 100), 32'sd5, 1'b0);
      send_item(key_pool[0], 32'd0, 32'sd0, 1'b0);
      send_item(key_pool[0], 32'hFFFF_FFFF, 32'sd1, 1'b0);
      apply_settings(8, 2, 1'b1, 32'd0);
      // EDP extremes, incl. zero and negative products
      send_item(key_pool[1], 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
      send_item(key_pool[1], 32'hFFFF_FFFF, 32'sh7FFF_FFFE, 1'b0);
      send_item(key_pool[1], 32'd3, 32'sh8000_0000, 1'b0);
      send_item(key_pool[3], 32'd100, 32'sd7, 1'b0);
      send_item(key_pool[3], 32'd0, 32'sd7, 1'b0);
      send_item(key_pool[4], 32'd50, 32'sd2, 1'b0);
      send_item(key_pool[4], 32'd50, -32'sd1, 1'b0);
      send_item(key_pool[4], 32'd40, 32'sd2, 1'b0);
      send_item(key_pool[2], 32'd10, 32'sd1, 1'b0);
   endtask

   task automatic random_item(input bit no_gap);
      logic [63:0]        key;
      logic [31:0]        tm;
      logic signed [31:0] en;
      int                 sel;
      key = key_pool[$urandom_range(0, POOL_N - 1)];
      sel = $urandom_range(0, 19);
      tm = (sel == 0) ? $urandom : (sel == 1) ? 32'd0 : $urandom_range(200, 1800);
      sel = $urandom_range(0, 19);
      en = (sel == 0) ? $urandom : (sel < 3) ? -$signed(32'($urandom_range(0, 50)))
            : $signed(32'($urandom_range(1, 3000)));
      send_item(key, tm, en, no_gap);
   endtask

   task automatic test_random_settings();
      int cores[8]  = '{1, 256, 8, 37, 16, 256, 3, 64};
      int starts[8] = '{1, 256, 2, 5, 1, 2, 256, 4};
      logic [31:0] th[8];
      th = '{32'd0, 32'hFFFF_FFFF, 32'd740, $urandom_range(0, 5000),
             32'd10, 32'd0, 32'd100000, 32'd1};
      for (int s = 0; s < 8; s++) begin
         apply_settings(cores[s], starts[s], s[0], th[s]);
         for (int n = 0; n < 230; n++) begin
            if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            random_item(1'b0);
         end
         burst_mode = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      long_hold = 1'b1;
      for (int n = 0; n < 40; n++) random_item(1'b1);
   endtask

   task automatic test_table_full();
      apply_settings(8, 2, 1'b0, 32'd740);
      for (int n = 0; n < 45; n++) begin
         if (n % 3 == 2) random_item(1'b0);
         else send_item({$urandom, $urandom}, $urandom_range(1, 2000),
               $urandom_range(1, 100), 1'b0);
      end
   endtask

   // response side: random stall before each transfer, plus one long hold
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            n = burst_mode ? 0 : $urandom_range(0, 9);
            if (n != 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
               rsp_stall <= 1'b0;
            end
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      region_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected response transfer at %0t", $time);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_thread_count !== want.threads || rsp_boost_write !== want.boost_wr ||
                  rsp_boost_value !== want.boost_val || rsp_table_full !== want.full) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch at %0t: threads %0d/%0d bw %b/%b bv %b/%b full %b/%b",
                     $time, want.threads, rsp_thread_count, want.boost_wr,
                     rsp_boost_write, want.boost_val, rsp_boost_value, want.full,
                     rsp_table_full);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_region_key = '0;
      req_elapsed_time = '0;
      req_energy = '0;
      csr_write = 1'b0;
      csr_index = CSR_CORE_COUNT;
      csr_data = '0;
      fail_count = 0;
      idle_cycles = 0;
      burst_mode = 1'b0;
      long_hold = 1'b0;
      cfg_cores = int'(RST_CORE_COUNT);
      cfg_start = int'(RST_START_THREADS);
      cfg_edp = RST_INITIAL_METRIC;
      cfg_thresh = RST_BOOST_THRESHOLD;
      used_regions = 0;
      prev_region = 0;
      for (int i = 0; i < SLOTS; i++) begin
         tags[i] = '0;
         phase[i] = PH_REPEAT;
         edp_metric[i] = 1'b0;
         thr_now[i] = 0;
         thr_last[i] = 0;
         thr_step[i] = 0;
         thr_best[i] = 0;
         score_best[i] = 0;
         t_boost_on[i] = 0;
         t_boost_off[i] = 0;
         boost_best[i] = 1'b1;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_N; i++) key_pool[i] = {$urandom, $urandom};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_settings();
      test_backpressure();
      test_table_full();

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

FILE: region_thread_count_search.f
rtl/core/rtc_pkg.sv
rtl/core/rtc_mem.sv
rtl/core/rtc_tags.sv
rtl/core/rtc_update.sv
rtl/core/region_thread_count_search.sv
rtl/core/rtc_checker.sv
sim/tb_top.sv
